// File: design/lcag_pkg.sv
// Shared types and constants for the Life grid block.
// Used by the sequencer, the rule logic and the top level; no dependencies.
package lcag_pkg;

  // Operation codes carried in s_tuser
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2,
    OP_CLEAR = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ACCESS,
    ST_PRIME,
    ST_TICK,
    ST_CLEAR,
    ST_DONE
  } state_t;

  // Memory port strobes from the sequencer
  typedef struct packed {
    logic re;
    logic we;
  } mem_ctl_t;

  localparam int COORD_W  = 6;
  localparam int COL_LSB  = 0;
  localparam int ROW_LSB  = 6;
  localparam int VAL_BIT  = 12;
  localparam int S_DATA_W = 16;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 8;

  // B3/S23 neighbor counts
  localparam logic [3:0] SURVIVE_LOW = 4'd2;
  localparam logic [3:0] BIRTH_COUNT = 4'd3;

endpackage

// File: design/lcag_mem.sv
// Row memory of the grid: one write port, one read port, registered read data.
// No package dependencies.
module lcag_mem #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/lcag_rule.sv
// Next-generation logic for one row of cells under B3/S23, all columns at once.
// Depends on lcag_pkg for the rule counts.
module lcag_rule
  import lcag_pkg::*;
#(
  parameter int COLS = 64
) (
  input  logic [COLS-1:0] above,
  input  logic [COLS-1:0] here,
  input  logic [COLS-1:0] below,
  output logic [COLS-1:0] next_row
);

  logic [COLS+1:0] ext_a, ext_h, ext_b;
  logic [3:0]      count [COLS];

  // pad with dead cells at both ends: fixed border
  assign ext_a = {1'b0, above, 1'b0};
  assign ext_h = {1'b0, here, 1'b0};
  assign ext_b = {1'b0, below, 1'b0};

  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      count[c] = 4'(ext_a[c]) + 4'(ext_a[c+1]) + 4'(ext_a[c+2])
               + 4'(ext_h[c]) + 4'(ext_h[c+2])
               + 4'(ext_b[c]) + 4'(ext_b[c+1]) + 4'(ext_b[c+2]);
      next_row[c] = (count[c] == BIRTH_COUNT) || (here[c] && count[c] == SURVIVE_LOW);
    end
  end

endmodule

// File: design/lcag_seq.sv
// Sequencer: decodes operations, runs read-modify-write, the row sweep of a
// generation and the clearing sweep, and holds the output register. Uses lcag_pkg.
module lcag_seq
  import lcag_pkg::*;
#(
  parameter int COLS = 64,
  parameter int ROWS = 64,
  parameter int AW   = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic [S_USER_W-1:0] s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,
  output mem_ctl_t            mem_ctl,
  output logic [AW-1:0]       waddr,
  output logic [COLS-1:0]     wdata,
  output logic [AW-1:0]       raddr,
  input  logic [COLS-1:0]     rdata,
  output logic [COLS-1:0]     above,
  output logic [COLS-1:0]     here,
  output logic [COLS-1:0]     below,
  input  logic [COLS-1:0]     next_row
);

  state_t               state, state_next;
  logic [AW-1:0]        wr_ptr, wr_ptr_next;
  logic [COLS-1:0]      above_next, here_next;
  func_t                op, op_next;
  logic [COORD_W-1:0]   col, col_next;
  logic [COORD_W-1:0]   row, row_next;
  logic                 val, val_next;
  logic                 res, res_next;
  logic                 out_valid, out_valid_next;
  logic                 out_bit, out_bit_next;
  logic                 last_row;
  logic                 in_grid;
  logic [COLS-1:0]      shifted;
  logic [COLS-1:0]      bit_mask;

  assign last_row = (wr_ptr == AW'(ROWS - 1));
  assign in_grid  = (32'(col) < COLS) && (32'(row) < ROWS);
  assign shifted  = rdata >> col;
  assign bit_mask = COLS'(1) << col;
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_DATA_W-1){1'b0}}, out_bit};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      wr_ptr    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      wr_ptr    <= wr_ptr_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    above   <= above_next;
    here    <= here_next;
    op      <= op_next;
    col     <= col_next;
    row     <= row_next;
    val     <= val_next;
    res     <= res_next;
    out_bit <= out_bit_next;
  end

  always_comb begin
    state_next     = state;
    wr_ptr_next    = wr_ptr;
    above_next     = above;
    here_next      = here;
    op_next        = op;
    col_next       = col;
    row_next       = row;
    val_next       = val;
    res_next       = res;
    out_valid_next = out_valid && !m_tready;
    out_bit_next   = out_bit;
    s_tready       = 1'b0;
    mem_ctl        = '0;
    waddr          = wr_ptr;
    wdata          = '0;
    raddr          = '0;
    below          = rdata;
    case (state)
      ST_INIT: begin
        mem_ctl.we = 1'b1;
        if (last_row) begin
          wr_ptr_next = '0;
          state_next  = ST_IDLE;
        end else begin
          wr_ptr_next = wr_ptr + 1'b1;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          op_next  = func_t'(s_tuser);
          col_next = s_tdata[COL_LSB +: COORD_W];
          row_next = s_tdata[ROW_LSB +: COORD_W];
          val_next = s_tdata[VAL_BIT];
          case (func_t'(s_tuser))
            OP_WRITE, OP_READ: begin
              mem_ctl.re = 1'b1;
              raddr      = AW'(s_tdata[ROW_LSB +: COORD_W]);
              state_next = ST_ACCESS;
            end
            OP_TICK: begin
              mem_ctl.re = 1'b1;
              raddr      = '0;
              state_next = ST_PRIME;
            end
            OP_CLEAR: begin
              wr_ptr_next = '0;
              state_next  = ST_CLEAR;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_ACCESS: begin
        res_next = 1'b0;
        if (in_grid) begin
          if (op == OP_READ) begin
            res_next = shifted[0];
          end else if (op == OP_WRITE) begin
            mem_ctl.we = 1'b1;
            waddr      = AW'(row);
            wdata      = val ? (rdata | bit_mask) : (rdata & ~bit_mask);
          end
        end
        state_next = ST_DONE;
      end
      ST_PRIME: begin
        // row 0 is here; fetch row 1
        here_next   = rdata;
        above_next  = '0;
        wr_ptr_next = '0;
        mem_ctl.re  = 1'b1;
        raddr       = AW'(1);
        state_next  = ST_TICK;
      end
      ST_TICK: begin
        // rdata holds row wr_ptr+1; old rows kept in above/here
        below      = last_row ? '0 : rdata;
        mem_ctl.we = 1'b1;
        wdata      = next_row;
        above_next = here;
        here_next  = rdata;
        if (32'(wr_ptr) + 32'd2 < ROWS) begin
          mem_ctl.re = 1'b1;
          raddr      = AW'(32'(wr_ptr) + 32'd2);
        end
        if (last_row) begin
          res_next   = 1'b0;
          state_next = ST_DONE;
        end else begin
          wr_ptr_next = wr_ptr + 1'b1;
        end
      end
      ST_CLEAR: begin
        mem_ctl.we = 1'b1;
        if (last_row) begin
          res_next   = 1'b0;
          state_next = ST_DONE;
        end else begin
          wr_ptr_next = wr_ptr + 1'b1;
        end
      end
      ST_DONE: begin
        // hold the result until the output register has room
        if (!out_valid || m_tready) begin
          out_valid_next = 1'b1;
          out_bit_next   = res;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: design/life_cellular_automaton_grid_top.sv
// Top level of the Game of Life grid block (B3/S23, fixed dead border).
// Uses lcag_pkg, lcag_mem, lcag_rule and lcag_seq.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready with the operation in s_tuser
//   (write cell, read cell, tick one generation, clear grid) and the cell
//   coordinates and value in s_tdata. Every accepted word yields exactly one
//   output word on m_tvalid/m_tready; m_tdata bit 0 is the cell value for a
//   read and 0 otherwise. Coordinates outside the grid: write is dropped,
//   read returns 0.
// Timing:
//   One word is in flight at a time. Read and write: one memory read, then one
//   modify/write back, then the output word; the next word is taken after
//   that. A tick: one row of cells is computed per cycle from the row
//   memory's single read port. A clear: zeros are written to every row.
// Reset:
//   rst is synchronous. After reset the block sweeps zeros through the row
//   memory with s_tready low.
// Stalls:
//   The output register holds a word until taken; the next input word is
//   accepted meanwhile, and its result waits until the register frees up.
module life_cellular_automaton_grid_top
  import lcag_pkg::*;
#(
  parameter int COLS = 64,
  parameter int ROWS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // col[5:0], row[11:6], cell_value[12], zero pad
  input  logic [S_USER_W-1:0] s_tuser,   // func[1:0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata    // read_value[0], zero pad
);

  localparam int AW = $clog2(ROWS);

  mem_ctl_t         mem_ctl;
  logic [AW-1:0]    waddr, raddr;
  logic [COLS-1:0]  wdata, rdata;
  logic [COLS-1:0]  above, here, below, next_row;

  lcag_mem #(
    .WIDTH (COLS),
    .DEPTH (ROWS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_ctl.we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (mem_ctl.re),
    .raddr (raddr),
    .rdata (rdata)
  );

  lcag_rule #(
    .COLS (COLS)
  ) u_rule (
    .above    (above),
    .here     (here),
    .below    (below),
    .next_row (next_row)
  );

  lcag_seq #(
    .COLS (COLS),
    .ROWS (ROWS),
    .AW   (AW)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .mem_ctl  (mem_ctl),
    .waddr    (waddr),
    .wdata    (wdata),
    .raddr    (raddr),
    .rdata    (rdata),
    .above    (above),
    .here     (here),
    .below    (below),
    .next_row (next_row)
  );

endmodule

// File: design/lcag_checker.sv
// Port-level checks for the Life grid top level, attached by bind.
// Depends on lcag_pkg for port widths.
module lcag_checker
  import lcag_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata
);

  // reset starts the initial zeroing sweep and empties the output register
  a_rst_busy: assert property (@(posedge clk) rst |=> !s_tready && !m_tvalid)
    else $error("block not busy and empty after reset");

  // one word in flight: busy right after acceptance
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second word accepted back to back");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[M_DATA_W-1:1] == '0))
    else $error("output pad bits not zero");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("output word changed while stalled");

endmodule

bind life_cellular_automaton_grid_top lcag_checker u_lcag_checker (.*);

// File: tb/tb_top.sv
// Self-checking bench for the Life grid block: random and directed cell
// operations, with a B3/S23 grid model predicting every output word.
// Depends on lcag_pkg and life_cellular_automaton_grid_top.
module tb_top;
  import lcag_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_ROWS = 64;
  localparam int GRID_COLS = 64;
  localparam int RANDOM_OPS = 900;

  typedef struct {
    func_t           func;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic            cell_value;
    bit              wait_idle;   // hold off until every result is back
  } grid_op_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [S_USER_W-1:0] s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  logic [GRID_COLS-1:0] life_grid [GRID_ROWS];
  grid_op_t pending_words [$];
  logic     read_values_due [$];
  grid_op_t on_bus;
  grid_op_t next_word;
  logic     due_value;
  int       words_offered = 0;
  int       words_in = 0;
  int       results_seen = 0;
  int       mismatches = 0;
  int       op_count = 0;
  bit       drain_next = 1'b0;
  int       hold_left = 0;
  bit       holdoff_done = 1'b0;

  life_cellular_automaton_grid_top #(
    .COLS(GRID_COLS),
    .ROWS(GRID_ROWS)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one operation to the grid model and return the expected read value.
  function automatic logic apply_grid_op(grid_op_t op);
    logic [GRID_COLS-1:0] prev [GRID_ROWS];
    logic result;
    int n, rr, cc;
    result = 1'b0;
    case (op.func)
      OP_WRITE: begin
        if (op.row < GRID_ROWS && op.col < GRID_COLS)
          life_grid[op.row][op.col] = op.cell_value;
      end
      OP_READ: begin
        if (op.row < GRID_ROWS && op.col < GRID_COLS)
          result = life_grid[op.row][op.col];
      end
      OP_TICK: begin
        prev = life_grid;
        for (int r = 0; r < GRID_ROWS; r++) begin
          for (int c = 0; c < GRID_COLS; c++) begin
            n = 0;
            for (int dr = -1; dr <= 1; dr++) begin
              for (int dc = -1; dc <= 1; dc++) begin
                rr = r + dr;
                cc = c + dc;
                // cells past the border count as dead
                if ((dr != 0 || dc != 0) && rr >= 0 && rr < GRID_ROWS &&
                    cc >= 0 && cc < GRID_COLS && prev[rr][cc])
                  n++;
              end
            end
            if (prev[r][c])
              life_grid[r][c] = (n == SURVIVE_LOW || n == BIRTH_COUNT);
            else
              life_grid[r][c] = (n == BIRTH_COUNT);
          end
        end
      end
      OP_CLEAR: begin
        for (int r = 0; r < GRID_ROWS; r++)
          life_grid[r] = '0;
      end
      default: ;
    endcase
    return result;
  endfunction

  task automatic queue_op(func_t f, int row, int col, int v);
    grid_op_t op;
    op.func       = f;
    op.row        = COORD_W'(row);
    op.col        = COORD_W'(col);
    op.cell_value = v[0];
    op.wait_idle  = drain_next;
    drain_next    = 1'b0;
    pending_words.push_back(op);
    op_count++;
  endtask

  // Sender: offer the next word once the current one is taken.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || words_in == words_offered) begin
      if (pending_words.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (pending_words[0].wait_idle && read_values_due.size() != 0) begin
        s_tvalid <= 1'b0;
      end else if (!(words_offered >= 300 && words_offered < 450) &&
                   $urandom_range(99) < 16) begin
        s_tvalid <= 1'b0;
      end else begin
        next_word = pending_words.pop_front();
        on_bus   <= next_word;
        s_tdata  <= {{(S_DATA_W - VAL_BIT - 1){1'b0}}, next_word.cell_value,
                     next_word.row, next_word.col};
        s_tuser  <= next_word.func;
        s_tvalid <= 1'b1;
        words_offered++;
      end
    end
  end

  // Receiver: random stalls, one long hold-off, one stretch always ready.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (!holdoff_done && results_seen >= 150) begin
      holdoff_done = 1'b1;
      hold_left    = 299;
      m_tready    <= 1'b0;
    end else if (results_seen >= 300 && results_seen < 450) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 16);
    end
  end

  // Check the outgoing word first, then predict the incoming one.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (read_values_due.size() == 0) begin
          $display("%0t: unexpected output word, actual m_tdata=%h", $time, m_tdata);
          mismatches++;
        end else begin
          due_value = read_values_due.pop_front();
          if (m_tdata !== {{(M_DATA_W - 1){1'b0}}, due_value}) begin
            $display("%0t: read_value mismatch, expected m_tdata=%h actual m_tdata=%h",
                     $time, {{(M_DATA_W - 1){1'b0}}, due_value}, m_tdata);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        read_values_due.push_back(apply_grid_op(on_bus));
        words_in++;
      end
    end
  end

  initial begin
    int kind, h, w, r0, c0, rr, cc, n, p;
    bit mid_drain_set;
    mid_drain_set = 1'b0;
    for (int r = 0; r < GRID_ROWS; r++)
      life_grid[r] = '0;

    // corners, then a blinker on the top edge and an L in the far corner
    queue_op(OP_WRITE, 0, 0, 1'b1);
    queue_op(OP_WRITE, GRID_ROWS - 1, GRID_COLS - 1, 1'b1);
    queue_op(OP_WRITE, 0, GRID_COLS - 1, 1'b1);
    queue_op(OP_WRITE, GRID_ROWS - 1, 0, 1'b1);
    queue_op(OP_READ, 0, 0, 1'b0);
    queue_op(OP_READ, GRID_ROWS - 1, GRID_COLS - 1, 1'b1);
    queue_op(OP_WRITE, 0, 0, 1'b0);
    queue_op(OP_READ, 0, 0, 1'b1);
    queue_op(OP_TICK, 63, 63, 1'b1);
    queue_op(OP_READ, GRID_ROWS - 1, 0, 1'b0);
    queue_op(OP_WRITE, 0, 0, 1'b1);
    queue_op(OP_WRITE, 0, 1, 1'b1);
    queue_op(OP_WRITE, 0, 2, 1'b1);
    queue_op(OP_TICK, 0, 0, 1'b0);
    queue_op(OP_READ, 1, 1, 1'b0);
    queue_op(OP_READ, 0, 0, 1'b0);
    queue_op(OP_READ, 0, 1, 1'b0);
    queue_op(OP_WRITE, GRID_ROWS - 2, GRID_COLS - 1, 1'b1);
    queue_op(OP_WRITE, GRID_ROWS - 1, GRID_COLS - 2, 1'b1);
    queue_op(OP_WRITE, GRID_ROWS - 1, GRID_COLS - 1, 1'b1);
    queue_op(OP_TICK, 21, 42, 1'b1);
    queue_op(OP_READ, GRID_ROWS - 2, GRID_COLS - 2, 1'b0);
    queue_op(OP_CLEAR, 63, 0, 1'b1);
    queue_op(OP_READ, 1, 1, 1'b0);
    queue_op(OP_READ, GRID_ROWS - 2, GRID_COLS - 2, 1'b0);
    drain_next = 1'b1;

    while (op_count < 25 + RANDOM_OPS) begin
      if (!mid_drain_set && op_count >= 500) begin
        drain_next    = 1'b1;
        mid_drain_set = 1'b1;
      end
      kind = $urandom_range(99);
      if (kind < 70) begin
        // seed a small patch, often against an edge, evolve it, probe around it
        h = $urandom_range(6, 3);
        w = $urandom_range(6, 3);
        case ($urandom_range(3))
          0:       r0 = 0;
          1:       r0 = GRID_ROWS - h;
          default: r0 = $urandom_range(GRID_ROWS - h);
        endcase
        case ($urandom_range(3))
          0:       c0 = 0;
          1:       c0 = GRID_COLS - w;
          default: c0 = $urandom_range(GRID_COLS - w);
        endcase
        for (int i = 0; i < h; i++)
          for (int j = 0; j < w; j++)
            if ($urandom_range(99) < 60)
              queue_op(OP_WRITE, r0 + i, c0 + j, $urandom_range(99) < 50);
        n = $urandom_range(4, 1);
        for (int i = 0; i < n; i++)
          queue_op(OP_TICK, $urandom_range(63), $urandom_range(63), $urandom_range(1));
        n = $urandom_range(12, 4);
        for (int i = 0; i < n; i++) begin
          rr = r0 + $urandom_range(h + 1) - 1;
          cc = c0 + $urandom_range(w + 1) - 1;
          if (rr < 0) rr = 0;
          if (rr > GRID_ROWS - 1) rr = GRID_ROWS - 1;
          if (cc < 0) cc = 0;
          if (cc > GRID_COLS - 1) cc = GRID_COLS - 1;
          queue_op(OP_READ, rr, cc, $urandom_range(1));
        end
      end else if (kind < 95) begin
        n = $urandom_range(6, 1);
        for (int i = 0; i < n; i++) begin
          p = $urandom_range(99);
          if (p < 40)
            queue_op(OP_WRITE, $urandom_range(63), $urandom_range(63), $urandom_range(1));
          else if (p < 80)
            queue_op(OP_READ, $urandom_range(63), $urandom_range(63), $urandom_range(1));
          else if (p < 97)
            queue_op(OP_TICK, $urandom_range(63), $urandom_range(63), $urandom_range(1));
          else
            queue_op(OP_CLEAR, $urandom_range(63), $urandom_range(63), $urandom_range(1));
        end
      end else begin
        queue_op(OP_CLEAR, $urandom_range(63), $urandom_range(63), $urandom_range(1));
        n = $urandom_range(3);
        for (int i = 0; i < n; i++)
          queue_op(OP_READ, $urandom_range(63), $urandom_range(63), $urandom_range(1));
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || s_tvalid || read_values_due.size() != 0)
      @(posedge clk);
    // let any stray word show up before closing
    repeat (GRID_ROWS + 8) @(posedge clk);

    if (read_values_due.size() != 0) begin
      $display("%0t: %0d output words never arrived", $time, read_values_due.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20ms;
    $display("%0t: timeout", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
